[rtl/core/bqenv_pkg.sv]
// Shared types, constants and coefficient table for the biquad envelope block.
// Used by the controller, the datapath and the top level. No dependencies.
package bqenv_pkg;

    localparam int WINDOW_LOG2_DEF = 6;
    localparam int BAND_COUNT      = 4;
    localparam int BAND_W          = $clog2(BAND_COUNT);

    localparam int SAMPLE_W   = 16;
    localparam int FILT_W     = 18;
    localparam int ENV_W      = 17;
    localparam int ENV_INT_W  = 18;
    localparam int MAG_W      = 18;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int HIT_W      = 32;
    localparam int RMS_W      = 16;
    localparam int ROOT_IN_W  = 32;
    localparam int DELAY_W    = 32;
    localparam int COEF_W     = 14;
    localparam int PROD_W     = COEF_W + DELAY_W;
    localparam int ACC_W      = 48;
    localparam int Q_SHIFT    = 12;
    localparam int SHIFT_W    = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam int CNT_W      = 4;
    localparam int ROOT_STEPS = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BAND_LIMIT_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_LIMIT_MID  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_LIMIT_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_SHIFT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_SHIFT   = 3'd4;

    localparam logic [ENV_W-1:0] LIMIT_LOW_RST  = 17'd800;
    localparam logic [ENV_W-1:0] LIMIT_MID_RST  = 17'd2400;
    localparam logic [ENV_W-1:0] LIMIT_HIGH_RST = 17'd3600;
    localparam logic [SHIFT_W-1:0] ATTACK_RST   = 4'd2;
    localparam logic [SHIFT_W-1:0] RELEASE_RST  = 4'd6;

    localparam int TAP_W = 3;
    localparam logic [TAP_W-1:0] TAP_X    = 3'd0;
    localparam logic [TAP_W-1:0] TAP_X1   = 3'd1;
    localparam logic [TAP_W-1:0] TAP_X2   = 3'd2;
    localparam logic [TAP_W-1:0] TAP_Y1   = 3'd3;
    localparam logic [TAP_W-1:0] TAP_Y2   = 3'd4;
    localparam int               MAC_TAPS = 5;

    localparam logic [1:0] BAND_ZERO  = 2'd0;
    localparam logic [1:0] BAND_ONE   = 2'd1;
    localparam logic [1:0] BAND_TWO   = 2'd2;
    localparam logic [1:0] BAND_THREE = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_FILT,
        ST_ENV,
        ST_BAND,
        ST_SUM,
        ST_ROOT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             load_in;
        logic             mac_mul;
        logic             mac_acc;
        logic [TAP_W-1:0] mac_sel;
        logic             filt;
        logic             env;
        logic             band;
        logic             sum;
        logic             root_step;
        logic             out_load;
    } t_cmd;

    typedef struct packed {
        logic closed;
    } t_stat;

    // Q12 biquad taps; feedback term on y2 carries its minus sign
    function automatic logic signed [COEF_W-1:0] tap_coef(input logic [TAP_W-1:0] sel);
        logic signed [COEF_W-1:0] c;
        case (sel)
            TAP_X:   c = 14'sd275;
            TAP_X1:  c = 14'sd550;
            TAP_X2:  c = 14'sd275;
            TAP_Y1:  c = 14'sd4682;
            TAP_Y2:  c = -14'sd1692;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

[rtl/core/bqenv_sqrt.sv]
// Bit-pair integer square root, one step per cycle while i_step is high, 16 steps for 32-bit input.
// Depends on bqenv_pkg.
module bqenv_sqrt (
    input  logic                                i_clk,
    input  logic                                i_load,
    input  logic [bqenv_pkg::ROOT_IN_W-1:0]     i_value,
    input  logic                                i_step,
    output logic [bqenv_pkg::RMS_W-1:0]         o_root
);
    import bqenv_pkg::*;

    logic [ROOT_IN_W-1:0] r_v;
    logic [ROOT_IN_W-1:0] r_r;
    logic [ROOT_IN_W-1:0] r_bit;
    logic [ROOT_IN_W-1:0] w_trial;

    assign w_trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_v   <= i_value;
            r_r   <= '0;
            r_bit <= ROOT_IN_W'(1) << (ROOT_IN_W - 2);
        end else if (i_step) begin
            if (r_v >= w_trial) begin
                r_v <= r_v - w_trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_root = r_r[RMS_W-1:0];

endmodule

[rtl/core/bqenv_ctrl.sv]
// Sequencer for the biquad envelope block: handshakes and datapath commands.
// Depends on bqenv_pkg.
module bqenv_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  bqenv_pkg::t_stat   i_stat,
    output bqenv_pkg::t_cmd    o_cmd
);
    import bqenv_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    logic              w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.mac_sel = r_cnt[TAP_W-1:0];
        n_out_valid = (r_out_valid && !i_out_ready);

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_cnt   = '0;
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                o_cmd.mac_mul = (r_cnt < CNT_W'(MAC_TAPS));
                o_cmd.mac_acc = (r_cnt != '0);
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MAC_TAPS)) begin
                    n_state = ST_FILT;
                end
            end
            ST_FILT: begin
                o_cmd.filt = 1'b1;
                n_state = ST_ENV;
            end
            ST_ENV: begin
                o_cmd.env = 1'b1;
                n_state = ST_BAND;
            end
            ST_BAND: begin
                o_cmd.band = 1'b1;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_cnt = '0;
                n_state = i_stat.closed ? ST_ROOT : ST_DONE;
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(ROOT_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/bqenv_dp.sv]
// Datapath: config registers, shared-multiplier biquad, envelope, bands,
// windowed mean square and output registers. Depends on bqenv_pkg, bqenv_sqrt.
module bqenv_dp #(
    parameter int WINDOW_LOG2 = bqenv_pkg::WINDOW_LOG2_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  bqenv_pkg::t_cmd                         i_cmd,
    output bqenv_pkg::t_stat                        o_stat,
    input  logic                                    i_cfg_we,
    input  logic [bqenv_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [bqenv_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic signed [bqenv_pkg::SAMPLE_W-1:0]   i_raw_sample,
    output logic signed [bqenv_pkg::FILT_W-1:0]     o_filtered,
    output logic [bqenv_pkg::ENV_W-1:0]             o_envelope,
    output logic [bqenv_pkg::BAND_W-1:0]            o_band,
    output logic [bqenv_pkg::HIT_W-1:0]             o_band_count,
    output logic [bqenv_pkg::RMS_W-1:0]             o_rms_value,
    output logic                                    o_rms_updated
);
    import bqenv_pkg::*;

    localparam int SUM_W = SQ_W + WINDOW_LOG2;

    localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(64'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] Y_MIN = -ACC_W'(64'sh8000_0000);
    localparam logic signed [DELAY_W-1:0] F_MAX = DELAY_W'(131071);
    localparam logic signed [DELAY_W-1:0] F_MIN = -DELAY_W'(131072);
    localparam logic [ENV_INT_W-1:0] ENV_SAT = ENV_INT_W'(131071);

    // configuration
    logic [ENV_W-1:0]   r_lim_low, r_lim_mid, r_lim_high;
    logic [SHIFT_W-1:0] r_att_shift, r_rel_shift;

    // filter state
    logic signed [SAMPLE_W-1:0] r_x, r_x1, r_x2;
    logic signed [DELAY_W-1:0]  r_y1, r_y2;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;

    logic signed [FILT_W-1:0]   r_f;
    logic [MAG_W-1:0]           r_mag;
    logic [ENV_INT_W-1:0]       r_env;
    logic [BAND_W-1:0]          r_band;
    logic [HIT_W-1:0]           r_hits [BAND_COUNT];
    logic [HIT_W-1:0]           r_cnt;
    logic [SQ_W-1:0]            r_sq;
    logic [SUM_W-1:0]           r_sum;
    logic [WINDOW_LOG2-1:0]     r_wcnt;
    logic                       r_closed;
    logic [RMS_W-1:0]           r_last;

    logic signed [COEF_W-1:0]   w_coef;
    logic signed [DELAY_W-1:0]  w_opnd;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [ACC_W-1:0]    w_shr;
    logic signed [DELAY_W-1:0]  w_y;
    logic signed [FILT_W-1:0]   w_f;
    logic signed [FILT_W:0]     w_fx;
    logic [MAG_W-1:0]           w_mag;
    logic [ENV_INT_W-1:0]       w_env;
    logic [BAND_W-1:0]          w_band;
    logic [SUM_W-1:0]           w_sum;
    logic [SUM_W-1:0]           w_mean;
    logic [ROOT_IN_W-1:0]       w_mean_sat;
    logic [RMS_W-1:0]           w_root;
    logic [RMS_W-1:0]           w_rms;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_low   <= LIMIT_LOW_RST;
            r_lim_mid   <= LIMIT_MID_RST;
            r_lim_high  <= LIMIT_HIGH_RST;
            r_att_shift <= ATTACK_RST;
            r_rel_shift <= RELEASE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BAND_LIMIT_LOW:  r_lim_low   <= i_cfg_data[ENV_W-1:0];
                REG_BAND_LIMIT_MID:  r_lim_mid   <= i_cfg_data[ENV_W-1:0];
                REG_BAND_LIMIT_HIGH: r_lim_high  <= i_cfg_data[ENV_W-1:0];
                REG_ATTACK_SHIFT:    r_att_shift <= i_cfg_data[SHIFT_W-1:0];
                REG_RELEASE_SHIFT:   r_rel_shift <= i_cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // shared tap multiplier
    always_comb begin
        case (i_cmd.mac_sel)
            TAP_X:   w_opnd = DELAY_W'(r_x);
            TAP_X1:  w_opnd = DELAY_W'(r_x1);
            TAP_X2:  w_opnd = DELAY_W'(r_x2);
            TAP_Y1:  w_opnd = r_y1;
            TAP_Y2:  w_opnd = r_y2;
            default: w_opnd = '0;
        endcase
    end

    assign w_coef = tap_coef(i_cmd.mac_sel);
    assign w_prod = w_coef * w_opnd;

    // floor by Q12, clamp to 32 and 18 bits
    assign w_shr = r_acc >>> Q_SHIFT;

    always_comb begin
        if (w_shr > Y_MAX) begin
            w_y = DELAY_W'(Y_MAX);
        end else if (w_shr < Y_MIN) begin
            w_y = DELAY_W'(Y_MIN);
        end else begin
            w_y = DELAY_W'(w_shr);
        end

        if (w_y > F_MAX) begin
            w_f = FILT_W'(F_MAX);
        end else if (w_y < F_MIN) begin
            w_f = FILT_W'(F_MIN);
        end else begin
            w_f = FILT_W'(w_y);
        end
    end

    assign w_fx  = (FILT_W + 1)'(w_f);
    assign w_mag = w_f[FILT_W-1] ? MAG_W'(-w_fx) : MAG_W'(w_fx);

    // envelope follower
    always_comb begin
        if (ENV_INT_W'(r_mag) > r_env) begin
            w_env = r_env + ((ENV_INT_W'(r_mag) - r_env) >> r_att_shift);
        end else begin
            w_env = r_env - ((r_env - ENV_INT_W'(r_mag)) >> r_rel_shift);
        end
    end

    // band in threshold order
    always_comb begin
        if (r_env < ENV_INT_W'(r_lim_low)) begin
            w_band = BAND_ZERO;
        end else if (r_env < ENV_INT_W'(r_lim_mid)) begin
            w_band = BAND_ONE;
        end else if (r_env < ENV_INT_W'(r_lim_high)) begin
            w_band = BAND_TWO;
        end else begin
            w_band = BAND_THREE;
        end
    end

    // window mean, saturated to 32 bits
    assign w_sum  = r_sum + SUM_W'(r_sq);
    assign w_mean = w_sum >> WINDOW_LOG2;
    assign w_mean_sat = (|w_mean[SUM_W-1:ROOT_IN_W]) ? '1 : w_mean[ROOT_IN_W-1:0];

    assign o_stat.closed = &r_wcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1   <= '0;
            r_x2   <= '0;
            r_y1   <= '0;
            r_y2   <= '0;
            r_env  <= '0;
            r_sum  <= '0;
            r_wcnt <= '0;
            r_last <= '0;
            for (int i = 0; i < BAND_COUNT; i++) begin
                r_hits[i] <= '0;
            end
        end else begin
            if (i_cmd.filt) begin
                r_x2 <= r_x1;
                r_x1 <= r_x;
                r_y2 <= r_y1;
                r_y1 <= w_y;
            end
            if (i_cmd.env) begin
                r_env <= w_env;
            end
            if (i_cmd.band) begin
                r_hits[w_band] <= r_hits[w_band] + HIT_W'(1);
            end
            if (i_cmd.sum) begin
                r_wcnt <= r_wcnt + WINDOW_LOG2'(1);
                r_sum  <= o_stat.closed ? '0 : w_sum;
            end
            if (i_cmd.out_load) begin
                r_last <= w_rms;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x   <= i_raw_sample;
            r_acc <= '0;
        end
        if (i_cmd.mac_mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.mac_acc) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.filt) begin
            r_f   <= w_f;
            r_mag <= w_mag;
        end
        if (i_cmd.band) begin
            r_band <= w_band;
            r_cnt  <= r_hits[w_band] + HIT_W'(1);
            r_sq   <= SQ_W'(r_mag) * SQ_W'(r_mag);
        end
        if (i_cmd.sum) begin
            r_closed <= o_stat.closed;
        end
    end

    bqenv_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_load  (i_cmd.sum),
        .i_value (w_mean_sat),
        .i_step  (i_cmd.root_step),
        .o_root  (w_root)
    );

    assign w_rms = r_closed ? w_root : r_last;

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_filtered    <= r_f;
            o_envelope    <= (r_env > ENV_SAT) ? ENV_W'(ENV_SAT) : r_env[ENV_W-1:0];
            o_band        <= r_band;
            o_band_count  <= r_cnt;
            o_rms_value   <= w_rms;
            o_rms_updated <= r_closed;
        end
    end

endmodule

[rtl/core/biquad_envelope_band_rms_top.sv]
// Each input passes through the MAC, filter, envelope, band and sum states;
// a window-closing sample adds 16 root steps, one bit pair per cycle. A
// sample is taken only when idle, after the last one is done; the five filter
// taps share one multiplier. A new sample is taken while a result waits.
// Reset (i_rst_n low, synchronous) clears filter, envelope, band counts, window
// and last RMS, and loads the register defaults.
module biquad_envelope_band_rms_top #(
    parameter int WINDOW_LOG2 = bqenv_pkg::WINDOW_LOG2_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic signed [bqenv_pkg::SAMPLE_W-1:0]   i_raw_sample,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [bqenv_pkg::FILT_W-1:0]     o_filtered,
    output logic [bqenv_pkg::ENV_W-1:0]             o_envelope,
    output logic [bqenv_pkg::BAND_W-1:0]            o_band,
    output logic [bqenv_pkg::HIT_W-1:0]             o_band_count,
    output logic [bqenv_pkg::RMS_W-1:0]             o_rms_value,
    output logic                                    o_rms_updated,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [bqenv_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [bqenv_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import bqenv_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    bqenv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    bqenv_dp #(
        .WINDOW_LOG2 (WINDOW_LOG2)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_raw_sample  (i_raw_sample),
        .o_filtered    (o_filtered),
        .o_envelope    (o_envelope),
        .o_band        (o_band),
        .o_band_count  (o_band_count),
        .o_rms_value   (o_rms_value),
        .o_rms_updated (o_rms_updated)
    );

endmodule
